>>> rtl/core/afq_pkg.sv
package afq_pkg;

	// lanes per request
	localparam int LANES = 8;
	// lanes on the result port
	localparam int OUT_LANES = 8;

	// front/back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// reciprocal: one quotient bit per step, 24 mantissa bits plus guard
	localparam int DIV_STEPS = 25;
	localparam int DIV_CW = $clog2(DIV_STEPS);

	// 1e-8 in binary32: exponent field and mantissa with hidden bit
	localparam logic [7:0]  EPS_EXP = 8'd100;
	localparam logic [23:0] EPS_MAN = 24'hABCC77;

	// 1/448 in binary32 (0x3B124925)
	localparam logic [7:0]  RCP_EXP = 8'd118;
	localparam logic [23:0] RCP_MAN = 24'h924925;

	localparam logic [7:0]  EXP_MAX = 8'hFF;
	localparam logic [31:0] QNAN_BIT = 32'h0040_0000;

	// E4M3 codes
	localparam logic [6:0] E4M3_MAXMAG = 7'h7E;
	localparam logic [7:0] E4M3_NEGMAX = 8'hFE;

	typedef struct packed {
		logic                  is_desc;
		logic [14:0]           peak;
		logic [LANES-1:0][15:0] elem;
	} afq_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} afq_qstat_t;

endpackage

>>> rtl/core/afq_if.sv
interface afq_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic        last;
	logic [15:0] elem_0;
	logic [15:0] elem_1;
	logic [15:0] elem_2;
	logic [15:0] elem_3;
	logic [15:0] elem_4;
	logic [15:0] elem_5;
	logic [15:0] elem_6;
	logic [15:0] elem_7;

	modport source(output valid, mode, last, elem_0, elem_1, elem_2, elem_3,
		elem_4, elem_5, elem_6, elem_7, input ready);
	modport sink(input valid, mode, last, elem_0, elem_1, elem_2, elem_3,
		elem_4, elem_5, elem_6, elem_7, output ready);
endinterface

interface afq_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] descale_bits;
	logic [7:0]  byte_0;
	logic [7:0]  byte_1;
	logic [7:0]  byte_2;
	logic [7:0]  byte_3;
	logic [7:0]  byte_4;
	logic [7:0]  byte_5;
	logic [7:0]  byte_6;
	logic [7:0]  byte_7;

	modport source(output valid, kind, descale_bits, byte_0, byte_1, byte_2, byte_3,
		byte_4, byte_5, byte_6, byte_7, input ready);
	modport sink(input valid, kind, descale_bits, byte_0, byte_1, byte_2, byte_3,
		byte_4, byte_5, byte_6, byte_7, output ready);
endinterface

>>> rtl/core/afq_queue.sv
module afq_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  afq_pkg::afq_entry_t push_ent,
	input  logic                pop,
	output afq_pkg::afq_entry_t head,
	output afq_pkg::afq_qstat_t qstat
);

	afq_pkg::afq_entry_t                  mem_q [afq_pkg::QDEPTH];
	logic [afq_pkg::QPTR_W-1:0]           wptr_q;
	logic [afq_pkg::QPTR_W-1:0]           rptr_q;
	logic [afq_pkg::QCNT_W-1:0]           cnt_q;

	assign head        = mem_q[rptr_q];
	assign qstat.full  = (cnt_q == afq_pkg::QCNT_W'(afq_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				mem_q[wptr_q] <= push_ent;
				wptr_q <= (wptr_q == afq_pkg::QPTR_W'(afq_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop)
				rptr_q <= (rptr_q == afq_pkg::QPTR_W'(afq_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> rtl/core/afq_front.sv
module afq_front (
	input  logic                clk,
	input  logic                arst_n,
	afq_req_if.sink             req,
	input  afq_pkg::afq_qstat_t qstat,
	output logic                push,
	output afq_pkg::afq_entry_t push_ent
);

	logic [14:0] peak_q;
	logic [14:0] peak_n;
	logic [7:0][15:0] raw;
	logic        accept;

	assign raw = {req.elem_7, req.elem_6, req.elem_5, req.elem_4,
		req.elem_3, req.elem_2, req.elem_1, req.elem_0};

	assign req.ready = !qstat.full;
	assign accept    = req.valid && req.ready;

	// running magnitude max, sign masked, compared as integer
	always_comb begin
		peak_n = peak_q;
		for (int i = 0; i < afq_pkg::LANES; i++) begin
			if (raw[i][14:0] > peak_n)
				peak_n = raw[i][14:0];
		end
	end

	always_comb begin
		push_ent.is_desc = !req.mode;
		push_ent.peak    = peak_n;
		for (int i = 0; i < afq_pkg::LANES; i++)
			push_ent.elem[i] = raw[i];
	end

	// only quantize requests and the closing scan request go to the back end
	assign push = accept && (req.mode || req.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (accept && !req.mode) begin
			peak_q <= req.last ? '0 : peak_n;
		end
	end

endmodule

>>> rtl/core/afq_back.sv
module afq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  afq_pkg::afq_entry_t head,
	input  afq_pkg::afq_qstat_t qstat,
	output logic                pop,
	afq_rsp_if.source           rsp
);

	typedef enum logic [2:0] {
		B_IDLE, B_QMUL, B_QCVT, B_DADD, B_DMUL, B_DRND, B_DIV, B_DOUT
	} bstate_t;

	typedef enum logic [1:0] {C_NORM, C_ZERO, C_INF, C_NAN} lcls_t;

	bstate_t                        state_q;
	afq_pkg::afq_entry_t            ent_q;
	logic [31:0]                    inv_q;

	// descale datapath
	logic                           spec_q;
	logic [7:0]                     sum_exp_q;
	logic [23:0]                    sum_man_q;
	logic [47:0]                    prod_q;
	logic [8:0]                     pexp_q;
	logic [31:0]                    desc_q;
	logic [25:0]                    rem_q;
	logic [afq_pkg::DIV_STEPS-1:0]  quo_q;
	logic [afq_pkg::DIV_CW-1:0]     cnt_q;

	// lane datapath
	logic [afq_pkg::LANES-1:0][31:0] lprod_q;
	logic signed [10:0]              lexp_q [afq_pkg::LANES];
	lcls_t                           lcls_q [afq_pkg::LANES];
	logic [afq_pkg::LANES-1:0]       lsgn_q;

	// result register
	logic                               ovalid_q;
	logic                               okind_q;
	logic [31:0]                        odesc_q;
	logic [afq_pkg::OUT_LANES-1:0][7:0] obyte_q;

	// product rounding to binary32, then to E4M3 with RNE and clamp
	function automatic logic [7:0] lane_cvt(lcls_t cls, logic s, logic [31:0] p,
		logic signed [10:0] ex);
		logic [23:0]        m24;
		logic               g;
		logic               st;
		logic               up;
		logic [24:0]        m25;
		logic signed [10:0] e;
		logic signed [10:0] ue;
		logic signed [10:0] t;
		logic [22:0]        mf;
		logic [26:0]        x;
		logic [7:0]         mag;
		logic [48:0]        w;
		logic [4:0]         sh;
		logic [7:0]         res;
		if (p[31]) begin
			m24 = p[31:8];
			g   = p[7];
			st  = |p[6:0];
			e   = ex + 11'sd1;
		end else begin
			m24 = p[30:7];
			g   = p[6];
			st  = |p[5:0];
			e   = ex;
		end
		up  = g && (st || m24[0]);
		m25 = {1'b0, m24} + 25'(up);
		if (m25[24]) begin
			mf = 23'd0;
			e  = e + 11'sd1;
		end else begin
			mf = m25[22:0];
		end
		ue  = e - 11'sd127;
		t   = ue + 11'sd7;
		x   = {t[3:0], mf};
		sh  = 5'(11'sd14 - ue);
		w   = {1'b1, mf, 25'd0} >> sh;
		mag = 8'd0;
		case (cls)
			C_NAN:  res = afq_pkg::E4M3_NEGMAX;
			C_INF:  res = {s, afq_pkg::E4M3_MAXMAG};
			C_ZERO: res = {s, 7'd0};
			default: begin
				if (e <= 11'sd0) begin
					res = {s, 7'd0};
				end else if (ue >= 11'sd9) begin
					res = {s, afq_pkg::E4M3_MAXMAG};
				end else if (ue >= -11'sd6) begin
					mag = {1'b0, x[26:20]} + 8'(x[19] && ((|x[18:0]) || x[20]));
					if (mag > {1'b0, afq_pkg::E4M3_MAXMAG})
						mag = {1'b0, afq_pkg::E4M3_MAXMAG};
					res = {s, mag[6:0]};
				end else if (ue < -11'sd11) begin
					res = {s, 7'd0};
				end else begin
					mag = w[32:25] + 8'(w[24] && ((|w[23:0]) || w[25]));
					res = {s, mag[6:0]};
				end
			end
		endcase
		return res;
	endfunction

	// ---- descale: peak + 1e-8 ----
	logic        add_spec;
	logic [31:0] add_spec_bits;
	logic [7:0]  add_exp;
	logic [23:0] add_man;

	always_comb begin
		logic [7:0]  ae;
		logic [23:0] am;
		logic [7:0]  be;
		logic [23:0] bm;
		logic [7:0]  se;
		logic [23:0] sm;
		logic [7:0]  d;
		logic [53:0] wide;
		logic [26:0] al;
		logic [27:0] s;
		logic [23:0] m24;
		logic        g;
		logic        st;
		logic [24:0] m25;
		logic [7:0]  e;
		ae = ent_q.peak[14:7];
		am = {1'b1, ent_q.peak[6:0], 16'd0};
		if (ae >= afq_pkg::EPS_EXP) begin
			be = ae; bm = am; se = afq_pkg::EPS_EXP; sm = afq_pkg::EPS_MAN;
		end else begin
			be = afq_pkg::EPS_EXP; bm = afq_pkg::EPS_MAN; se = ae; sm = am;
		end
		d    = be - se;
		wide = {sm, 3'd0, 27'd0} >> d;
		if (d >= 8'd27)
			al = 27'd1;
		else
			al = wide[53:27] | {26'd0, |wide[26:0]};
		s = {1'b0, bm, 3'd0} + {1'b0, al};
		if (s[27]) begin
			m24 = s[27:4]; g = s[3]; st = |s[2:0]; e = be + 8'd1;
		end else begin
			m24 = s[26:3]; g = s[2]; st = |s[1:0]; e = be;
		end
		m25 = {1'b0, m24} + 25'(g && (st || m24[0]));
		if (m25[24]) begin
			add_man = m25[24:1];
			add_exp = e + 8'd1;
		end else begin
			add_man = m25[23:0];
			add_exp = e;
		end
		// zero or subnormal peak is far below the rounding point of 1e-8
		if (ae == '0) begin
			add_man = afq_pkg::EPS_MAN;
			add_exp = afq_pkg::EPS_EXP;
		end
		add_spec      = (ae == afq_pkg::EXP_MAX);
		add_spec_bits = {1'b0, ent_q.peak, 16'd0} |
			((ent_q.peak[6:0] != '0) ? afq_pkg::QNAN_BIT : 32'd0);
	end

	// ---- descale: product rounding ----
	logic [31:0] rnd_bits;

	always_comb begin
		logic [23:0] m24;
		logic        g;
		logic        st;
		logic [24:0] m25;
		logic [8:0]  e;
		if (prod_q[47]) begin
			m24 = prod_q[47:24]; g = prod_q[23]; st = |prod_q[22:0]; e = pexp_q + 9'd1;
		end else begin
			m24 = prod_q[46:23]; g = prod_q[22]; st = |prod_q[21:0]; e = pexp_q;
		end
		m25 = {1'b0, m24} + 25'(g && (st || m24[0]));
		if (m25[24])
			e = e + 9'd1;
		rnd_bits = {1'b0, e[7:0], m25[22:0]};
	end

	// ---- reciprocal rounding ----
	logic [31:0] inv_bits;

	always_comb begin
		logic [23:0] m24;
		logic [23:0] mr;
		logic [7:0]  e;
		m24 = quo_q[afq_pkg::DIV_STEPS-1:1];
		mr  = m24 + 24'(quo_q[0] && ((rem_q != '0) || m24[0]));
		e   = (desc_q[22:0] == '0) ? (8'd254 - desc_q[30:23]) : (8'd253 - desc_q[30:23]);
		if (spec_q)
			inv_bits = (desc_q[22:0] != '0) ? desc_q : 32'd0;
		else
			inv_bits = {1'b0, e, mr[22:0]};
	end

	// ---- lane products ----
	logic [afq_pkg::LANES-1:0][31:0] lprod_n;
	logic signed [10:0]              lexp_n [afq_pkg::LANES];
	lcls_t                           lcls_n [afq_pkg::LANES];

	always_comb begin
		logic [7:0] ie;
		logic       i_nan;
		logic       i_inf;
		logic       i_zero;
		logic [7:0] e;
		logic       b_nan;
		logic       b_inf;
		logic       b_zero;
		ie     = inv_q[30:23];
		i_nan  = (ie == afq_pkg::EXP_MAX) && (inv_q[22:0] != '0);
		i_inf  = (ie == afq_pkg::EXP_MAX) && (inv_q[22:0] == '0);
		i_zero = (ie == '0);
		for (int i = 0; i < afq_pkg::LANES; i++) begin
			e      = ent_q.elem[i][14:7];
			b_nan  = (e == afq_pkg::EXP_MAX) && (ent_q.elem[i][6:0] != '0);
			b_inf  = (e == afq_pkg::EXP_MAX) && (ent_q.elem[i][6:0] == '0);
			b_zero = (e == '0);
			lprod_n[i] = 32'({1'b1, ent_q.elem[i][6:0]}) * 32'({1'b1, inv_q[22:0]});
			lexp_n[i]  = $signed({3'd0, e}) + $signed({3'd0, ie}) - 11'sd127;
			if (b_nan || i_nan || (b_inf && i_zero) || (b_zero && i_inf))
				lcls_n[i] = C_NAN;
			else if (b_inf || i_inf)
				lcls_n[i] = C_INF;
			else if (b_zero || i_zero)
				lcls_n[i] = C_ZERO;
			else
				lcls_n[i] = C_NORM;
		end
	end

	logic [25:0] div_d;
	assign div_d = {2'b01, desc_q[22:0]};

	assign pop = (state_q == B_IDLE) && !qstat.empty && !ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			inv_q    <= '0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (ovalid_q && rsp.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						ent_q   <= head;
						state_q <= head.is_desc ? B_DADD : B_QMUL;
					end
				end
				B_QMUL: begin
					lprod_q <= lprod_n;
					for (int i = 0; i < afq_pkg::LANES; i++) begin
						lexp_q[i] <= lexp_n[i];
						lcls_q[i] <= lcls_n[i];
						lsgn_q[i] <= ent_q.elem[i][15];
					end
					state_q <= B_QCVT;
				end
				B_QCVT: begin
					for (int i = 0; i < afq_pkg::OUT_LANES; i++) begin
						if (i < afq_pkg::LANES)
							obyte_q[i] <= lane_cvt(lcls_q[i], lsgn_q[i], lprod_q[i], lexp_q[i]);
						else
							obyte_q[i] <= '0;
					end
					okind_q  <= 1'b0;
					odesc_q  <= '0;
					ovalid_q <= 1'b1;
					state_q  <= B_IDLE;
				end
				B_DADD: begin
					spec_q    <= add_spec;
					desc_q    <= add_spec_bits;
					sum_exp_q <= add_exp;
					sum_man_q <= add_man;
					state_q   <= add_spec ? B_DOUT : B_DMUL;
				end
				B_DMUL: begin
					prod_q  <= 48'(sum_man_q) * 48'(afq_pkg::RCP_MAN);
					pexp_q  <= {1'b0, sum_exp_q} + {1'b0, afq_pkg::RCP_EXP} - 9'd127;
					state_q <= B_DRND;
				end
				B_DRND: begin
					desc_q  <= rnd_bits;
					rem_q   <= (rnd_bits[22:0] == '0) ? 26'h080_0000 : 26'h100_0000;
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (rem_q >= div_d) begin
						rem_q <= (rem_q - div_d) << 1;
						quo_q <= {quo_q[afq_pkg::DIV_STEPS-2:0], 1'b1};
					end else begin
						rem_q <= rem_q << 1;
						quo_q <= {quo_q[afq_pkg::DIV_STEPS-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == afq_pkg::DIV_CW'(afq_pkg::DIV_STEPS - 1))
						state_q <= B_DOUT;
				end
				B_DOUT: begin
					inv_q    <= inv_bits;
					okind_q  <= 1'b1;
					odesc_q  <= desc_q;
					obyte_q  <= '0;
					ovalid_q <= 1'b1;
					state_q  <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.kind         = okind_q;
	assign rsp.descale_bits = odesc_q;
	assign rsp.byte_0       = obyte_q[0];
	assign rsp.byte_1       = obyte_q[1];
	assign rsp.byte_2       = obyte_q[2];
	assign rsp.byte_3       = obyte_q[3];
	assign rsp.byte_4       = obyte_q[4];
	assign rsp.byte_5       = obyte_q[5];
	assign rsp.byte_6       = obyte_q[6];
	assign rsp.byte_7       = obyte_q[7];

endmodule

>>> rtl/core/absmax_fp8_quantizer.sv
// Per-tensor FP8 (E4M3) quantizer, two passes over the tensor. Scan requests
// (mode 0) fold the sign-masked bfloat16 magnitudes of all eight lanes into a
// running maximum in the front end, one request per cycle while the queue is
// not full, and give no result. The scan request marked last closes the
// pass: the back end forms descale = (max + 1e-8) * (1/448) in binary32, a
// correctly rounded reciprocal by a 25-step restoring divider, returns the
// descale word (kind 1) and keeps the reciprocal for the next quantize pass.
// That request runs through add, multiply, round, divider steps and write in
// the back end (a NaN or infinite peak skips to write). Quantize requests
// (mode 1) go through pop, eight lane multiplies by the stored reciprocal,
// then rounding, clamp to +-448 and conversion to E4M3 with round to nearest
// even (kind 0). The back end starts a request only once the result register
// is free. A two-entry queue parts the front end from the back end, so scan
// requests keep streaming while a descale is being worked out. Quantizing
// before any scan uses a reciprocal of zero; NaN products come out as 0xFE.
module absmax_fp8_quantizer (
	input  logic      clk,
	input  logic      arst_n,
	afq_req_if.sink   req,
	afq_rsp_if.source rsp
);

	afq_pkg::afq_entry_t push_ent;
	afq_pkg::afq_entry_t head;
	afq_pkg::afq_qstat_t qstat;
	logic                push;
	logic                pop;

	// accept, track the peak, classify
	afq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.qstat    (qstat),
		.push     (push),
		.push_ent (push_ent)
	);

	afq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// descale/reciprocal sequencer and lane quantizers
	afq_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

>>> rtl/core/afq_checker.sv
module afq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        kind,
	input logic [31:0] descale_bits,
	input logic [63:0] bytes
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(kind) && $stable(descale_bits) && $stable(bytes))
		else $error("result changed while stalled");

	a_desc_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind |-> bytes == 64'd0)
		else $error("descale result carries lane bytes");

	a_quant_desc: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !kind |-> descale_bits == 32'd0)
		else $error("quantize result carries descale word");

	// descale comes from a magnitude, never negative
	a_desc_sign: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind |-> !descale_bits[31])
		else $error("negative descale");

endmodule

bind absmax_fp8_quantizer afq_checker u_afq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (rsp.valid),
	.ready        (rsp.ready),
	.kind         (rsp.kind),
	.descale_bits (rsp.descale_bits),
	.bytes        ({rsp.byte_7, rsp.byte_6, rsp.byte_5, rsp.byte_4,
		rsp.byte_3, rsp.byte_2, rsp.byte_1, rsp.byte_0})
);
